FILE: design/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types, constants and register codes of the stepper ramp generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int DEF_NUM_MOTORS = 2;
    localparam int DEF_COUNT_BITS = 24;
    localparam int NUM_REGS       = 6;
    localparam int REG_IDX_BITS   = 3;
    localparam int IN_BITS        = 28;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_START  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_TGT0   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TGT1   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_RAMP   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_PULSE  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_HOLD   = 3'd5;

    // operation codes passed from front to back
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_OBST   = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    typedef struct packed {
        logic [15:0] ramp_start;
        logic [15:0] tgt0;
        logic [15:0] tgt1;
        logic [15:0] max_ramp;
        logic [9:0]  pulse_high;
        logic [15:0] hold;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  motor;
        logic [31:0] count;
        logic        dir;
    } cmd_t;

endpackage

FILE: design/srpg_front.sv
// ----------------------------------------------------------------------------
// srpg_front
// Accept input transfers, classify them and push commands into a short queue.
// ----------------------------------------------------------------------------
module srpg_front
    import srpg_pkg::*;
#(
    parameter int NUM_MOTORS = DEF_NUM_MOTORS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_BITS-1:0]   in_data,
    output logic                 q_valid,
    input  logic                 q_pop,
    output cmd_t                 q_cmd
);

    // keep only the count bits the motors can hold
    localparam logic [23:0] CNT_MASK = (COUNT_BITS >= 24) ? 24'hFFFFFF
                                     : 24'((33'd1 << COUNT_BITS) - 33'd1);

    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cmd;
    logic       push, pop;

    always_comb begin
        logic mode_b, motor_b, obst_b;
        logic [23:0] cnt_in;
        motor_b = in_data[0];
        cnt_in  = in_data[24:1] & CNT_MASK;
        obst_b  = in_data[26];
        mode_b  = in_data[27];
        cmd.motor = {2'b00, motor_b};
        cmd.count = 32'(cnt_in);
        cmd.dir   = in_data[25];
        if (mode_b) begin
            if (cnt_in == '0 || 32'(motor_b) >= NUM_MOTORS)
                cmd.op = OP_IGNORE;
            else
                cmd.op = OP_START;
        end else if (obst_b) begin
            cmd.op = OP_OBST;
        end else begin
            cmd.op = OP_TICK;
        end
    end

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= cmd;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: design/srpg_div.sv
// ----------------------------------------------------------------------------
// srpg_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module srpg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [5:0]  n_reg;
    logic        busy_reg;
    logic [16:0] trial;

    assign trial    = {r_reg[15:0], q_reg[47]};
    assign quotient = q_reg;
    assign done     = busy_reg && (n_reg == 6'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= 6'd0;
        end else if (start) begin
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
            n_reg    <= 6'd48;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            if (n_reg == 6'd0) begin
                busy_reg <= 1'b0;
            end else begin
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[46:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[46:0], 1'b0};
                end
                n_reg <= n_reg - 6'd1;
            end
        end
    end

endmodule

FILE: design/srpg_back.sv
// ----------------------------------------------------------------------------
// srpg_back
// Execute queued commands motor by motor and present one result per command.
// ----------------------------------------------------------------------------
module srpg_back
    import srpg_pkg::*;
#(
    parameter int NUM_MOTORS = DEF_NUM_MOTORS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_valid,
    output logic       q_pop,
    input  cmd_t       q_cmd,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [6:0] res_data
);

    localparam int MB = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOTOR = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [COUNT_BITS-1:0] rem_reg   [NUM_MOTORS];
    logic [COUNT_BITS-1:0] tot_reg   [NUM_MOTORS];
    logic [15:0]           ramp_reg  [NUM_MOTORS];
    logic                  high_reg  [NUM_MOTORS];
    logic [15:0]           ticks_reg [NUM_MOTORS];
    logic                  dir_reg   [NUM_MOTORS];

    logic [2:0]  state_reg;
    cmd_t        cmd_reg;
    logic [MB-1:0] m_reg;
    logic        ign_reg;
    logic        out_valid_reg;
    logic [6:0]  out_reg;
    logic [6:0]  out_next;

    logic        div_start, div_done;
    logic [47:0] div_q;
    logic        neg_reg;
    logic [16:0] base_reg;
    logic        use_sub_reg;
    logic [47:0] dividend_reg;

    // ramp delay operands for the motor in hand
    logic [15:0]           tgt;
    logic [16:0]           diff;
    logic                  diff_neg;
    logic [15:0]           dmag;
    logic [COUNT_BITS-1:0] done_steps;
    logic [COUNT_BITS-1:0] rem_c;
    logic [15:0]           ramp_c;
    logic                  in_accel, in_decel;
    logic [15:0]           num;
    logic [31:0]           prod;

    always_comb begin
        rem_c      = rem_reg[m_reg];
        ramp_c     = ramp_reg[m_reg];
        tgt        = (m_reg == '0) ? cfg.tgt0 : cfg.tgt1;
        diff       = {1'b0, cfg.ramp_start} - {1'b0, tgt};
        diff_neg   = diff[16];
        dmag       = diff_neg ? 16'(-diff) : diff[15:0];
        done_steps = tot_reg[m_reg] - rem_c;
        in_accel   = 32'(done_steps) < 32'(ramp_c);
        in_decel   = 32'(rem_c) <= 32'(ramp_c);
        // both terms stay below the ramp length inside the ramp
        num        = in_accel ? 16'(done_steps) : ramp_c - 16'(rem_c);
    end

    assign prod = dmag * num;

    srpg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (ramp_reg[m_reg]),
        .done     (div_done),
        .quotient (div_q)
    );

    // final delay: base -/+ quotient, clamped to 16 bits
    logic signed [49:0] dly;
    logic [15:0]        dly_c;
    logic [15:0]        dly_load;
    always_comb begin
        logic signed [49:0] qs;
        qs = neg_reg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
        dly = use_sub_reg ? $signed(50'(base_reg)) - qs : $signed(50'(base_reg)) + qs;
        if (dly < 0)               dly_c = 16'd0;
        else if (dly > 50'sd65535) dly_c = 16'hFFFF;
        else                       dly_c = dly[15:0];
        dly_load = (dly_c == 16'd0) ? 16'd0 : dly_c - 16'd1;
    end

    logic [15:0] pulse_load, hold_load;
    assign pulse_load = (cfg.pulse_high == 10'd0) ? 16'd0 : 16'(cfg.pulse_high - 10'd1);
    assign hold_load  = (cfg.hold == 16'd0) ? 16'd0 : cfg.hold - 16'd1;

    logic [15:0] half;
    assign half = (32'(cmd_reg.count) >> 1) > 32'(cfg.max_ramp) ? cfg.max_ramp
                : 16'(cmd_reg.count >> 1);

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;
    assign div_start = (state_reg == ST_DIV);

    always_comb begin
        logic [6:0] r;
        r = '0;
        r[0] = high_reg[0];
        r[2] = dir_reg[0];
        r[4] = (rem_reg[0] != '0);
        if (NUM_MOTORS > 1) begin
            r[1] = high_reg[NUM_MOTORS > 1 ? 1 : 0];
            r[3] = dir_reg[NUM_MOTORS > 1 ? 1 : 0];
            r[5] = (rem_reg[NUM_MOTORS > 1 ? 1 : 0] != '0);
        end
        r[6] = ign_reg;
        out_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                rem_reg[i]   <= '0;
                tot_reg[i]   <= '0;
                ramp_reg[i]  <= '0;
                high_reg[i]  <= 1'b0;
                ticks_reg[i] <= '0;
                dir_reg[i]   <= 1'b0;
            end
        end else begin
            if (out_valid_reg && res_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        cmd_reg <= q_cmd;
                        ign_reg <= (q_cmd.op == OP_IGNORE);
                        m_reg   <= (q_cmd.op == OP_START) ? MB'(q_cmd.motor) : '0;
                        unique case (q_cmd.op)
                            OP_IGNORE: state_reg <= ST_OUT;
                            OP_START:  state_reg <= ST_MOTOR;
                            OP_OBST: begin
                                for (int i = 0; i < NUM_MOTORS; i++) begin
                                    high_reg[i]  <= 1'b0;
                                    ticks_reg[i] <= hold_load;
                                end
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_MOTOR;
                        endcase
                    end
                end
                ST_MOTOR: begin
                    // one motor per visit; tick sweeps all motors
                    if (cmd_reg.op == OP_START) begin
                        rem_reg[m_reg]   <= COUNT_BITS'(cmd_reg.count);
                        tot_reg[m_reg]   <= COUNT_BITS'(cmd_reg.count);
                        dir_reg[m_reg]   <= cmd_reg.dir;
                        high_reg[m_reg]  <= 1'b0;
                        ticks_reg[m_reg] <= '0;
                        ramp_reg[m_reg]  <= half;
                        state_reg        <= ST_OUT;
                    end else if (rem_c == '0 || ticks_reg[m_reg] != '0 ||
                                 !high_reg[m_reg]) begin
                        if (rem_c != '0) begin
                            if (ticks_reg[m_reg] != '0)
                                ticks_reg[m_reg] <= ticks_reg[m_reg] - 16'd1;
                            else begin
                                high_reg[m_reg]  <= 1'b1;
                                ticks_reg[m_reg] <= pulse_load;
                            end
                        end
                        if (32'(m_reg) == NUM_MOTORS - 1) state_reg <= ST_OUT;
                        else m_reg <= m_reg + MB'(1);
                    end else begin
                        // end of high phase: compute low delay
                        neg_reg <= diff_neg;
                        if (ramp_c == 16'd0 || (!in_accel && !in_decel)) begin
                            dividend_reg <= '0;
                            base_reg     <= {1'b0, tgt};
                            use_sub_reg  <= 1'b0;
                        end else begin
                            dividend_reg <= 48'(prod);
                            if (in_accel) begin
                                base_reg    <= {1'b0, cfg.ramp_start};
                                use_sub_reg <= 1'b1;
                            end else begin
                                base_reg    <= {1'b0, tgt};
                                use_sub_reg <= 1'b0;
                            end
                        end
                        state_reg <= (ramp_c == 16'd0) ? ST_WAIT : ST_DIV;
                    end
                end
                ST_DIV: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (div_done || ramp_c == 16'd0) begin
                        high_reg[m_reg]  <= 1'b0;
                        ticks_reg[m_reg] <= (ramp_c == 16'd0)
                            ? ((tgt == 16'd0) ? 16'd0 : tgt - 16'd1) : dly_load;
                        rem_reg[m_reg]   <= rem_c - COUNT_BITS'(1);
                        if (32'(m_reg) == NUM_MOTORS - 1) state_reg <= ST_OUT;
                        else begin
                            m_reg     <= m_reg + MB'(1);
                            state_reg <= ST_MOTOR;
                        end
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg) begin
                        out_reg       <= out_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: design/stepper_ramp_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_unit
// Two-motor trapezoidal step pulse generator with stream in/out ports.
// ----------------------------------------------------------------------------
// Each input transfer is a start command or one timer tick (tuser selects
// which) and yields one result transfer with the pin levels after it. A front
// stage classifies transfers into a two-entry queue; the back stage visits the
// motors one at a time. An obstacle or ignored command goes straight to the
// result, a start loads one motor, and a tick visits each motor in turn. A
// motor that ends its high phase waits for the 48-step serial divider that
// interpolates the ramp delay; the divider is skipped with a zero ramp length.
// Further transfers wait in the queue meanwhile.
// Registers are read live: write them while idle.
module stepper_ramp_pulse_generator_unit
    import srpg_pkg::*;
#(
    parameter int NUM_MOTORS = DEF_NUM_MOTORS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // tdata: motor, step_count[23:0], direction, obstacle; tuser: mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    // tdata: step_level_first, step_level_second, dir_level_first,
    //        dir_level_second, busy_first, busy_second, command_ignored
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata
);

    cfg_t cfg_reg;
    logic q_valid, q_pop;
    cmd_t q_cmd;
    logic [6:0] res;

    assign cfg_ready = 1'b1;

    // hold the register file; drop writes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_start  <= 16'd3570;
            cfg_reg.tgt0        <= 16'd1000;
            cfg_reg.tgt1        <= 16'd1000;
            cfg_reg.max_ramp    <= 16'd1800;
            cfg_reg.pulse_high  <= 10'd100;
            cfg_reg.hold        <= 16'd500;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START: cfg_reg.ramp_start  <= cfg_data;
                REG_TGT0:  cfg_reg.tgt0        <= cfg_data;
                REG_TGT1:  cfg_reg.tgt1        <= cfg_data;
                REG_RAMP:  cfg_reg.max_ramp    <= cfg_data;
                REG_PULSE: cfg_reg.pulse_high  <= cfg_data[9:0];
                REG_HOLD:  cfg_reg.hold        <= cfg_data;
                default: ;
            endcase
        end
    end

    srpg_front #(.NUM_MOTORS(NUM_MOTORS), .COUNT_BITS(COUNT_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  ({s_tuser, s_tdata[26:0]}),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    srpg_back #(.NUM_MOTORS(NUM_MOTORS), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res)
    );

    assign m_tdata = {1'b0, res};

endmodule
